// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the FIR convolution filter unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the same cycle as ante
`define AST_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AST_SAME(lbl, clk, rst, ante, cons, msg)
`define AST_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/fcf_pkg.sv =====
// Shared types and constants of the FIR convolution filter
`timescale 1ns / 1ps

package fcf_pkg;

  // Payload widths
  localparam int COEF_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 6;
  localparam int ACC_W    = 38;

  // Digit-serial multiply: radix-16 over the sample word
  localparam int DIG_W    = 4;
  localparam int DIGITS   = SAMPLE_W / DIG_W;
  localparam int DCNT_W   = $clog2(DIGITS);
  localparam int MUL_W    = COEF_W + DIG_W + 1;
  localparam int PROD_W   = COEF_W + SAMPLE_W;

  // Configuration port
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;
  localparam int TAP_W    = 6;
  localparam logic [TAP_W-1:0] TAP_RESET = 6'd38;

  // Register word index
  localparam logic REG_TAP_COUNT = 1'b0;

  // Item action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Sequencer commands to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic accum;
  } mac_ctl_t;

  typedef struct packed {
    logic digit_last;
  } mac_sts_t;

endpackage

// ===== hw/rtl/fcf_if.sv =====
// Valid/ready channel interfaces for filter input and output items
`timescale 1ns / 1ps

interface fcf_in_if;
  import fcf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [INDEX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0]   coef_value;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       last_sample;

  modport source (
    output valid, action, coef_index, coef_value, sample_value, last_sample,
    input  ready
  );

  modport sink (
    input  valid, action, coef_index, coef_value, sample_value, last_sample,
    output ready
  );
endinterface

interface fcf_out_if;
  import fcf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] filtered_value;
  logic                    last_output;

  modport source (
    output valid, filtered_value, last_output,
    input  ready
  );

  modport sink (
    input  valid, filtered_value, last_output,
    output ready
  );
endinterface

// ===== hw/rtl/fir_convolution_filter_unit.sv =====
// A sample item is shifted into the history, then each of the T active taps is walked:
// one RAM read, one operand load, four digit steps, one add; then the sum is emitted.
// A last sample adds T-1 tail results, each with a zero shifted in; a load stays in idle.
// Items are taken only in idle, not while a sample is in work; a held result stalls only the emit.
// Reset sets tap_count to 38 and marks kernel and history entries as zero (valid bits).
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fir_convolution_filter_unit #(
  parameter int MAX_TAPS = 38
) (
  input  logic                         clk,
  input  logic                         rst,
  fcf_in_if.sink                       in_ch,
  fcf_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fcf_pkg::PADDR_W-1:0]  paddr,
  input  logic [fcf_pkg::PDATA_W-1:0]  pwdata,
  output logic [fcf_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import fcf_pkg::*;

  localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CMPW = INDEX_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_t;

  state_t                     state;
  logic [TAP_W-1:0]           tap_count;
  logic [AW-1:0]              wp;
  logic [AW-1:0]              rp;
  logic [AW-1:0]              k;
  logic [AW-1:0]              taps_m1;
  logic [AW-1:0]              taps_m1_next;
  logic [AW-1:0]              flush_cnt;
  logic [AW-1:0]              wp_inc;
  logic [AW-1:0]              rp_dec;
  logic                       last_q;
  logic [SAMPLE_W-1:0]        samp_q;
  logic [MAX_TAPS-1:0]        hv;
  logic [MAX_TAPS-1:0]        kv;
  logic                       hv_q;
  logic                       kv_q;
  logic                       out_v;
  logic signed [ACC_W-1:0]    out_val;
  logic                       out_last;
  logic                       accept;
  logic                       load_ok;
  logic                       samp_go;
  logic                       emit_go;
  logic                       emit_last;
  logic                       fin_emit;
  logic                       cfg_wr;
  logic                       reg_idx;
  logic [COEF_W-1:0]          kern_rdata;
  logic [SAMPLE_W-1:0]        hist_rdata;
  logic signed [ACC_W-1:0]    acc;
  mac_ctl_t                   mac_ctl;
  mac_sts_t                   mac_sts;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == REG_TAP_COUNT) ? PDATA_W'(tap_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TAP_RESET;
    end else if (cfg_wr && reg_idx == REG_TAP_COUNT) begin
      tap_count <= pwdata[TAP_W-1:0];
    end
  end

  // Active taps less one: zero means one tap, clamp above the store depth
  always_comb begin
    if (tap_count == '0) begin
      taps_m1_next = '0;
    end else if (CMPW'(tap_count) > CMPW'(MAX_TAPS)) begin
      taps_m1_next = AW'(MAX_TAPS - 1);
    end else begin
      taps_m1_next = AW'(tap_count - 1'b1);
    end
  end

  // Handshake and pointer arithmetic
  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load_ok     = accept && (in_ch.action == ACT_LOAD) &&
                       (CMPW'(in_ch.coef_index) < CMPW'(MAX_TAPS));
  assign samp_go     = accept && (in_ch.action == ACT_SAMPLE);
  assign wp_inc      = (wp == AW'(MAX_TAPS - 1)) ? '0 : wp + 1'b1;
  assign rp_dec      = (rp == '0) ? AW'(MAX_TAPS - 1) : rp - 1'b1;
  assign emit_go     = !out_v || out_ch.ready;
  assign emit_last   = last_q && (flush_cnt == taps_m1);
  assign fin_emit    = (state == ST_EMIT) && emit_go && emit_last;

  assign out_ch.valid          = out_v;
  assign out_ch.filtered_value = out_val;
  assign out_ch.last_output    = out_last;

  // Kernel and sample history stores
  fcf_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_kern_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (AW'(in_ch.coef_index)),
    .wdata (in_ch.coef_value),
    .raddr (k),
    .rdata (kern_rdata)
  );

  fcf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (state == ST_SHIFT),
    .waddr (wp_inc),
    .wdata (samp_q),
    .raddr (rp),
    .rdata (hist_rdata)
  );

  // Valid bits read alongside the RAM data
  always_ff @(posedge clk) begin
    kv_q <= kv[k];
    hv_q <= hv[rp];
  end

  // Sequencer commands
  always_comb begin
    mac_ctl.clear = (state == ST_SHIFT);
    mac_ctl.load  = (state == ST_LOAD);
    mac_ctl.step  = (state == ST_MUL);
    mac_ctl.accum = (state == ST_ACC);
  end

  fcf_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .coef      (kern_rdata),
    .coef_ok   (kv_q),
    .sample    (hist_rdata),
    .sample_ok (hv_q),
    .sts       (mac_sts),
    .acc       (acc)
  );

  // Sequencer: shift one sample in, walk the taps, emit the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      k         <= '0;
      taps_m1   <= '0;
      flush_cnt <= '0;
      last_q    <= 1'b0;
      hv        <= '0;
      kv        <= '0;
      out_v     <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      // Drop the held item once taken, unless a new one replaces it
      if (out_ch.ready && !(state == ST_EMIT && emit_go)) begin
        out_v <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (load_ok) begin
            kv[AW'(in_ch.coef_index)] <= 1'b1;
          end
          if (samp_go) begin
            samp_q    <= in_ch.sample_value;
            last_q    <= in_ch.last_sample;
            taps_m1   <= taps_m1_next;
            flush_cnt <= '0;
            state     <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          // Tail shifts push zeros: leave their entries marked invalid
          hv[wp_inc] <= (flush_cnt == '0);
          wp         <= wp_inc;
          rp         <= wp_inc;
          k          <= '0;
          state      <= ST_READ;
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mac_sts.digit_last) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (k == taps_m1) begin
            state <= ST_EMIT;
          end else begin
            k     <= k + 1'b1;
            rp    <= rp_dec;
            state <= ST_READ;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_v    <= 1'b1;
            out_val  <= acc;
            out_last <= emit_last;
            if (last_q && !emit_last) begin
              flush_cnt <= flush_cnt + 1'b1;
              samp_q    <= '0;
              state     <= ST_SHIFT;
            end else begin
              if (fin_emit) begin
                hv <= '0;
              end
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer
  `AST_NEXT(a_sample_starts_shift, clk, rst, samp_go, state == ST_SHIFT, "no shift after sample")
  `AST_SAME(a_tap_in_range, clk, rst, state == ST_ACC, k <= taps_m1, "tap past active taps")
  `AST_NEXT(a_clear_last, clk, rst, fin_emit, hv == '0 && out_last, "history not cleared")

endmodule

// ===== hw/rtl/fcf_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module fcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 38,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry each cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fcf_mac.sv =====
// Digit-serial multiply-accumulate unit: one 4-bit sample digit per cycle while stepped
`timescale 1ns / 1ps

module fcf_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  fcf_pkg::mac_ctl_t               ctl,
  input  logic [fcf_pkg::COEF_W-1:0]      coef,
  input  logic                            coef_ok,
  input  logic [fcf_pkg::SAMPLE_W-1:0]    sample,
  input  logic                            sample_ok,
  output fcf_pkg::mac_sts_t               sts,
  output logic signed [fcf_pkg::ACC_W-1:0] acc
);
  import fcf_pkg::*;

  logic signed [COEF_W-1:0] creg;
  logic [SAMPLE_W-1:0]      sreg;
  logic signed [PROD_W-1:0] prod;
  logic [DCNT_W-1:0]        dcnt;
  logic signed [DIG_W:0]    digit;
  logic signed [MUL_W-1:0]  part;
  logic signed [PROD_W-1:0] prod_next;

  // Top digit carries the sample sign, lower digits are unsigned
  always_comb begin
    if (dcnt == '0) begin
      digit = {sreg[SAMPLE_W-1], sreg[SAMPLE_W-1 -: DIG_W]};
    end else begin
      digit = {1'b0, sreg[SAMPLE_W-1 -: DIG_W]};
    end
    part      = creg * digit;
    prod_next = (prod <<< DIG_W) + PROD_W'(part);
  end

  assign sts.digit_last = (dcnt == DCNT_W'(DIGITS - 1));

  // Digit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (ctl.load) begin
      dcnt <= '0;
    end else if (ctl.step) begin
      dcnt <= dcnt + 1'b1;
    end
  end

  // Operand shift registers, partial product and accumulator
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      creg <= coef_ok ? $signed(coef) : '0;
      sreg <= sample_ok ? sample : '0;
      prod <= '0;
    end else if (ctl.step) begin
      sreg <= sreg << DIG_W;
      prod <= prod_next;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.accum) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule
